### hw/rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// shared types and constants of the trilinear enlargement span unit
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int PIX_W      = 8;
    localparam int CNT_W      = $clog2(PIX_W);
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [4:0] X_FACTOR_RESET = 5'd2;
    localparam logic [4:0] Y_FACTOR_RESET = 5'd2;
    localparam logic [4:0] T_FACTOR_RESET = 5'd2;
    localparam logic [3:0] T_PHASE_RESET  = 4'd0;

    typedef enum logic [1:0] {
        REG_X_FACTOR,
        REG_Y_FACTOR,
        REG_T_FACTOR,
        REG_T_PHASE
    } t_reg_idx;

    typedef struct packed {
        logic [4:0] x_factor;
        logic [4:0] y_factor;
        logic [4:0] t_factor;
        logic [3:0] t_phase;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP1,
        S_PREP2,
        S_PREP3,
        S_DLOAD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep1;
        logic prep2;
        logic prep3;
        logic div_load;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic last_px;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/tes_regs.sv
// ----------------------------------------------------------------------------
// tes_regs
// apb register file holding the enlargement factors and temporal phase
// ----------------------------------------------------------------------------
module tes_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tes_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tes_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tes_pkg::CFG_DATA_W-1:0]  prdata,
    output tes_pkg::t_cfg                   o_cfg
);
    import tes_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[3:2]);
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_factor <= X_FACTOR_RESET;
            r_cfg.y_factor <= Y_FACTOR_RESET;
            r_cfg.t_factor <= T_FACTOR_RESET;
            r_cfg.t_phase  <= T_PHASE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_X_FACTOR: r_cfg.x_factor <= pwdata[4:0];
                REG_Y_FACTOR: r_cfg.y_factor <= pwdata[4:0];
                REG_T_FACTOR: r_cfg.t_factor <= pwdata[4:0];
                REG_T_PHASE:  r_cfg.t_phase  <= pwdata[3:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_X_FACTOR: prdata = CFG_DATA_W'(r_cfg.x_factor);
            REG_Y_FACTOR: prdata = CFG_DATA_W'(r_cfg.y_factor);
            REG_T_FACTOR: prdata = CFG_DATA_W'(r_cfg.t_factor);
            REG_T_PHASE:  prdata = CFG_DATA_W'(r_cfg.t_phase);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/tes_ctrl.sv
// ----------------------------------------------------------------------------
// tes_ctrl
// sequencer: accept a request, prepare sums, divide and emit each pixel
// ----------------------------------------------------------------------------
module tes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tes_pkg::t_sts i_sts,
    output tes_pkg::t_cmd o_cmd
);
    import tes_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PREP1;
            S_PREP1: n_state = S_PREP2;
            S_PREP2: n_state = S_PREP3;
            S_PREP3: n_state = S_DLOAD;
            S_DLOAD: n_state = S_DIV;
            S_DIV:   if (i_sts.div_last) n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last_px ? S_IDLE : S_DLOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_PREP1: o_cmd.prep1    = 1'b1;
            S_PREP2: o_cmd.prep2    = 1'b1;
            S_PREP3: o_cmd.prep3    = 1'b1;
            S_DLOAD: o_cmd.div_load = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_EMIT:  o_cmd.emit     = i_sts.out_free;
            default: o_cmd          = '0;
        endcase
    end

endmodule

### hw/rtl/tes_dp.sv
// ----------------------------------------------------------------------------
// tes_dp
// datapath: corner capture, weight sums, restoring divider, output register
// ----------------------------------------------------------------------------
module tes_dp #(
    parameter int MAX_FACTOR = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tes_pkg::t_cfg             i_cfg,
    input  tes_pkg::t_cmd             i_cmd,
    output tes_pkg::t_sts             o_sts,
    input  logic [7:0]                i_cur_here,
    input  logic [7:0]                i_cur_right,
    input  logic [7:0]                i_cur_down,
    input  logic [7:0]                i_cur_diag,
    input  logic [7:0]                i_next_here,
    input  logic [7:0]                i_next_right,
    input  logic [7:0]                i_next_down,
    input  logic [7:0]                i_next_diag,
    input  logic                      i_right_edge,
    input  logic                      i_bottom_edge,
    input  logic [3:0]                i_sub_row,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [tes_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_last_in_run
);
    import tes_pkg::*;

    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int RW   = (FW > 5) ? FW : 5;
    localparam int COLW = PIX_W + FW;
    localparam int AW   = PIX_W + 2 * FW;
    localparam int SW   = 3 * FW;
    localparam int SUMW = PIX_W + 3 * FW;
    localparam int DW   = SUMW + 1;

    // factor and phase clamping
    logic [RW-1:0] w_xr, w_yr, w_tr, w_tp, w_sr, w_tm1, w_ym1;
    logic [FW-1:0] w_xf, w_yf, w_tf, w_t, w_i;

    assign w_xr = RW'(i_cfg.x_factor);
    assign w_yr = RW'(i_cfg.y_factor);
    assign w_tr = RW'(i_cfg.t_factor);
    assign w_tp = RW'(i_cfg.t_phase);
    assign w_sr = RW'(i_sub_row);

    assign w_xf = (w_xr == '0) ? FW'(1) :
                  (w_xr > RW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(w_xr);
    assign w_yf = (w_yr == '0) ? FW'(1) :
                  (w_yr > RW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(w_yr);
    assign w_tf = (w_tr == '0) ? FW'(1) :
                  (w_tr > RW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : FW'(w_tr);

    assign w_tm1 = RW'(w_tf) - RW'(1);
    assign w_ym1 = RW'(w_yf) - RW'(1);
    assign w_t   = (w_tp > w_tm1) ? FW'(w_tm1) : FW'(w_tp);
    assign w_i   = (w_sr > w_ym1) ? FW'(w_ym1) : FW'(w_sr);

    // edge replication per frame
    logic [7:0] w_h [2];
    logic [7:0] w_r [2];
    logic [7:0] w_d [2];
    logic [7:0] w_g [2];
    logic [7:0] w_rr [2];
    logic [7:0] w_dd [2];
    logic [7:0] w_gg [2];

    assign w_h[0] = i_cur_here;
    assign w_r[0] = i_cur_right;
    assign w_d[0] = i_cur_down;
    assign w_g[0] = i_cur_diag;
    assign w_h[1] = i_next_here;
    assign w_r[1] = i_next_right;
    assign w_d[1] = i_next_down;
    assign w_g[1] = i_next_diag;

    always_comb begin
        for (int f = 0; f < 2; f++) begin
            w_rr[f] = i_right_edge  ? w_h[f] : w_r[f];
            w_dd[f] = i_bottom_edge ? w_h[f] : w_d[f];
            if (i_bottom_edge) begin
                w_gg[f] = w_rr[f];
            end else if (i_right_edge) begin
                w_gg[f] = w_dd[f];
            end else begin
                w_gg[f] = w_g[f];
            end
        end
    end

    // item registers
    logic [7:0]      r_c [8];
    logic [FW-1:0]   r_i;
    logic [FW-1:0]   w_wy0, w_wt0;
    logic [COLW-1:0] r_col [4];
    logic [2*FW-1:0] r_xy;
    logic [AW-1:0]   r_a, r_b;
    logic [SW-1:0]   r_scale;
    logic [SUMW-1:0] r_sum;
    logic [FW-1:0]   r_j;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int f = 0; f < 2; f++) begin
                r_c[4*f+0] <= w_h[f];
                r_c[4*f+1] <= w_rr[f];
                r_c[4*f+2] <= w_dd[f];
                r_c[4*f+3] <= w_gg[f];
            end
            r_i <= w_i;
        end
        if (i_cmd.prep1) begin
            r_col[0] <= COLW'(r_c[0]) * COLW'(w_wy0) + COLW'(r_c[2]) * COLW'(r_i);
            r_col[1] <= COLW'(r_c[1]) * COLW'(w_wy0) + COLW'(r_c[3]) * COLW'(r_i);
            r_col[2] <= COLW'(r_c[4]) * COLW'(w_wy0) + COLW'(r_c[6]) * COLW'(r_i);
            r_col[3] <= COLW'(r_c[5]) * COLW'(w_wy0) + COLW'(r_c[7]) * COLW'(r_i);
            r_xy     <= (2*FW)'(w_xf) * (2*FW)'(w_yf);
        end
        if (i_cmd.prep2) begin
            r_a     <= AW'(r_col[0]) * AW'(w_wt0) + AW'(r_col[2]) * AW'(w_t);
            r_b     <= AW'(r_col[1]) * AW'(w_wt0) + AW'(r_col[3]) * AW'(w_t);
            r_scale <= SW'(r_xy) * SW'(w_tf);
        end
        if (i_cmd.prep3) begin
            r_sum <= SUMW'(r_a) * SUMW'(w_xf);
            r_j   <= '0;
        end else if (i_cmd.emit) begin
            r_sum <= r_sum + SUMW'(r_b) - SUMW'(r_a);
            r_j   <= r_j + FW'(1);
        end
    end

    assign w_wy0 = w_yf - r_i;
    assign w_wt0 = w_tf - w_t;

    // restoring divider, one quotient bit a cycle
    logic [DW-1:0]    r_rem, r_dvs;
    logic [PIX_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= DW'(r_sum) + DW'(r_scale >> 1);
            r_dvs <= DW'(r_scale) << (PIX_W - 1);
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_q   <= {r_q[PIX_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[PIX_W-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_pix;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pix  <= r_q;
            r_last <= o_sts.last_px;
        end
    end

    assign o_sts.div_last = (r_cnt == CNT_W'(PIX_W - 1));
    assign o_sts.last_px  = (r_j == (w_xf - FW'(1)));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_pix;
    assign o_last_in_run = r_last;

endmodule

### hw/rtl/trilinear_enlarge_span_unit.sv
// ----------------------------------------------------------------------------
// trilinear_enlarge_span_unit
// trilinear enlargement of one source cell into a run of output pixels
// ----------------------------------------------------------------------------
// One request carries the eight corner samples of a source cell, the edge
// flags and the sub-row; it yields X pixels (X the clamped x_factor), the
// last one flagged. A request is worked through in order: a capture step,
// the weight sums and the scale built in states PREP1 to PREP3, then per
// pixel one divider load, eight steps of the one-bit restoring divider and
// one emit step, which waits while the output is stalled. The next request
// is taken once the last pixel sits in the output register.
// ----------------------------------------------------------------------------
module trilinear_enlarge_span_unit #(
    parameter int MAX_FACTOR = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tes_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tes_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tes_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_cur_here,
    input  logic [7:0]                      i_cur_right,
    input  logic [7:0]                      i_cur_down,
    input  logic [7:0]                      i_cur_diag,
    input  logic [7:0]                      i_next_here,
    input  logic [7:0]                      i_next_right,
    input  logic [7:0]                      i_next_down,
    input  logic [7:0]                      i_next_diag,
    input  logic                            i_right_edge,
    input  logic                            i_bottom_edge,
    input  logic [3:0]                      i_sub_row,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_pixel_out,
    output logic                            o_last_in_run
);
    import tes_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    assign pready = 1'b1;

    tes_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    tes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tes_dp #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cur_here    (i_cur_here),
        .i_cur_right   (i_cur_right),
        .i_cur_down    (i_cur_down),
        .i_cur_diag    (i_cur_diag),
        .i_next_here   (i_next_here),
        .i_next_right  (i_next_right),
        .i_next_down   (i_next_down),
        .i_next_diag   (i_next_diag),
        .i_right_edge  (i_right_edge),
        .i_bottom_edge (i_bottom_edge),
        .i_sub_row     (i_sub_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_out   (o_pixel_out),
        .o_last_in_run (o_last_in_run)
    );

endmodule

### hw/rtl/tes_checker.sv
// ----------------------------------------------------------------------------
// tes_checker
// port-level checks on the request and result handshakes of the span unit
// ----------------------------------------------------------------------------
module tes_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_pixel_out,
    input logic       o_last_in_run
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pixel_out) && $stable(o_last_in_run))
        else $error("stalled result changed");

    // one run at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while a run is starting");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_in_run |-> o_in_stall)
        else $error("request taken before the run finished");

endmodule

bind trilinear_enlarge_span_unit tes_checker u_tes_checker (.*);
